FILE: hw/rtl/rqi8_pkg.sv
package rqi8_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned DivW     = 31;
  localparam int unsigned AccW     = 32;

  localparam logic [CfgIdxW-1:0] CFG_DIVISOR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET  = 2'd1;

  localparam logic [1:0] LAST_LANE = 2'd3;
  localparam logic [7:0] SAT_POS   = 8'h7f;
  localparam logic [7:0] SAT_NEG   = 8'h80;

  typedef struct packed {
    logic [31:0] sample;
    logic        final_element;
  } in_t;

  typedef struct packed {
    logic [31:0] packed_word;
    logic [2:0]  bytes_valid;
    logic        final_word;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_EMIT
  } state_e;

endpackage

FILE: hw/rtl/rqi8_div.sv
module rqi8_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] sum_i,
  input  logic [30:0] divisor_i,
  output logic        done_o,
  output logic [7:0]  byte_o
);

  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [30:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic        neg_q, neg_d;

  logic [31:0] shifted;
  logic [32:0] diff;
  logic        ge;
  logic        hi_nz;
  logic        big;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_q, quo_q[31]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_i};
  assign ge      = ~diff[32];

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = 5'd31;
      rem_d = '0;
      neg_d = sum_i[31];
      quo_d = sum_i[31] ? (32'd0 - sum_i) : sum_i;
    end else if (run_q) begin
      rem_d = ge ? diff[30:0] : shifted[30:0];
      quo_d = {quo_q[30:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  // saturate to int8
  assign hi_nz = |quo_q[31:8];

  always_comb begin
    if (neg_q) begin
      big    = hi_nz | (quo_q[7] & (|quo_q[6:0]));
      byte_o = big ? rqi8_pkg::SAT_NEG : (8'd0 - quo_q[7:0]);
    end else begin
      big    = hi_nz | quo_q[7];
      byte_o = big ? rqi8_pkg::SAT_POS : quo_q[7:0];
    end
  end

  assign done_o = done_q;

endmodule

FILE: hw/rtl/requantize_int32_to_int8_pack.sv
// Each input item gets the bias added into a register, then loads the bit-serial
// divider, which finds the quotient one bit at a time; once the divider finishes,
// the byte is packed into the word. A new item is accepted only after the last one
// is through, and packing waits while a full word finds the output register busy.
// The output register holds a word while the next item is processed.
// Reset (rst_ni low, asynchronous): divisor 1, offset 0, lane and partial word cleared.
module requantize_int32_to_int8_pack (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rqi8_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [rqi8_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  rqi8_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output rqi8_pkg::out_t                       out_data_o
);

  rqi8_pkg::state_e state_q, state_d;

  logic [30:0] divisor_q;
  logic [31:0] offset_q;
  logic [31:0] sum_q;
  logic        last_q;
  logic [1:0]  lane_q;
  logic [23:0] partial_q;
  logic        out_valid_q;
  rqi8_pkg::out_t out_q;

  logic [30:0] div_eff;
  logic        div_start;
  logic        div_done;
  logic [7:0]  div_byte;
  logic        in_xfer;
  logic        word_out;
  logic        out_free;
  logic        emit_out;
  logic        emit_keep;
  logic [31:0] word;

  assign div_eff = (divisor_q == 31'd0) ? 31'd1 : divisor_q;

  rqi8_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .sum_i     (sum_q),
    .divisor_i (div_eff),
    .done_o    (div_done),
    .byte_o    (div_byte)
  );

  assign word_out = (lane_q == rqi8_pkg::LAST_LANE) | last_q;
  assign out_free = ~out_valid_q | out_ready_i;
  assign word     = {8'd0, partial_q} | ({24'd0, div_byte} << {lane_q, 3'b000});

  always_comb begin
    state_d = state_q;
    case (state_q)
      rqi8_pkg::ST_IDLE:  if (in_valid_i) state_d = rqi8_pkg::ST_START;
      rqi8_pkg::ST_START: state_d = rqi8_pkg::ST_DIV;
      rqi8_pkg::ST_DIV:   if (div_done) state_d = rqi8_pkg::ST_EMIT;
      rqi8_pkg::ST_EMIT:  if (!word_out || out_free) state_d = rqi8_pkg::ST_IDLE;
      default:            state_d = rqi8_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    emit_out   = 1'b0;
    emit_keep  = 1'b0;
    case (state_q)
      rqi8_pkg::ST_IDLE:  in_ready_o = 1'b1;
      rqi8_pkg::ST_START: div_start = 1'b1;
      rqi8_pkg::ST_EMIT: begin
        emit_out  = word_out & out_free;
        emit_keep = ~word_out;
      end
      default: ;
    endcase
  end

  assign in_xfer = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rqi8_pkg::ST_IDLE;
      divisor_q   <= 31'd1;
      offset_q    <= '0;
      lane_q      <= '0;
      partial_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rqi8_pkg::CFG_DIVISOR: divisor_q <= cfg_data_i[30:0];
          rqi8_pkg::CFG_OFFSET:  offset_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (emit_out) begin
        lane_q      <= '0;
        partial_q   <= '0;
        out_valid_q <= 1'b1;
      end else begin
        if (emit_keep) begin
          lane_q    <= lane_q + 2'd1;
          partial_q <= word[23:0];
        end
        if (out_ready_i) out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sum_q  <= in_data_i.sample + offset_q;
      last_q <= in_data_i.final_element;
    end
    if (emit_out) begin
      out_q.packed_word <= word;
      out_q.bytes_valid <= {1'b0, lane_q} + 3'd1;
      out_q.final_word  <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == rqi8_pkg::ST_DIV))
    else $error("divider finished outside divide phase");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_out |-> (!out_valid_q || out_ready_i))
    else $error("pending output word overwritten");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == rqi8_pkg::ST_START))
    else $error("accepted item did not start division");

  a_bytes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.bytes_valid != 3'd0 && out_q.bytes_valid <= 3'd4))
    else $error("bytes_valid out of range");

endmodule

FILE: tb/tb_requantize_int32_to_int8_pack.sv
`timescale 1ns / 100ps

module tb_requantize_int32_to_int8_pack;
  import rqi8_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;
  localparam int DRAIN_CYCLES = 48;
  localparam int PHASE_ITEMS  = 128;
  localparam int NUM_PHASES   = 12;

  class requant_scoreboard;
    logic [DivW-1:0] divisor;
    logic [AccW-1:0] offset;
    logic [1:0]      lane;
    logic [23:0]     partial;
    out_t            words_due[$];
    int              errors;
    int              words_seen;

    function new();
      divisor    = 1;
      offset     = '0;
      lane       = '0;
      partial    = '0;
      errors     = 0;
      words_seen = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CFG_DIVISOR) begin
        divisor = data[DivW-1:0];
      end else if (idx == CFG_OFFSET) begin
        offset = data;
      end
    endfunction

    // bias, truncating divide, clip to int8
    function logic [7:0] requant_byte(logic [AccW-1:0] s);
      logic [31:0] sum;
      logic [31:0] mag;
      logic [31:0] quo;
      logic [31:0] dv;
      sum = s + offset;
      dv  = (divisor == '0) ? 32'd1 : {1'b0, divisor};
      mag = sum[31] ? (32'd0 - sum) : sum;
      quo = mag / dv;
      if (sum[31]) begin
        if (quo >= {24'd0, SAT_NEG}) return SAT_NEG;
        quo = 32'd0 - quo;
        return quo[7:0];
      end
      if (quo > {24'd0, SAT_POS}) return SAT_POS;
      return quo[7:0];
    endfunction

    function void note_input(in_t it);
      logic [7:0]  lane_byte;
      logic [31:0] word;
      out_t        res;
      lane_byte = requant_byte(it.sample);
      word = {8'd0, partial} | ({24'd0, lane_byte} << (8 * lane));
      if (lane == LAST_LANE || it.final_element) begin
        res.packed_word = word;
        res.bytes_valid = {1'b0, lane} + 3'd1;
        res.final_word  = it.final_element;
        words_due.push_back(res);
        lane    = '0;
        partial = '0;
      end else begin
        partial = word[23:0];
        lane    = lane + 2'd1;
      end
    endfunction

    function void check_word(out_t got);
      out_t want;
      words_seen++;
      if (words_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h/%0d/%0d", $time,
                 got.packed_word, got.bytes_valid, got.final_word);
        errors++;
        return;
      end
      want = words_due.pop_front();
      if (got.packed_word !== want.packed_word) begin
        $display("%0t: packed_word expected %h actual %h", $time,
                 want.packed_word, got.packed_word);
        errors++;
      end
      if (got.bytes_valid !== want.bytes_valid) begin
        $display("%0t: bytes_valid expected %0d actual %0d", $time,
                 want.bytes_valid, got.bytes_valid);
        errors++;
      end
      if (got.final_word !== want.final_word) begin
        $display("%0t: final_word expected %0d actual %0d", $time,
                 want.final_word, got.final_word);
        errors++;
      end
    endfunction

    function int pending();
      return words_due.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;

  requant_scoreboard sb;
  bit idle_on;
  int n_items;
  int n_finals;
  int n_settings;

  requantize_int32_to_int8_pack uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) sb.check_word(out_data_o);
  end

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      int stall;
      stall = idle_on ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic in_t mk_item(logic [31:0] s, logic last);
    in_t it;
    it.sample        = s;
    it.final_element = last;
    return it;
  endfunction

  function automatic logic [31:0] pick_sample();
    int     mode;
    int     qv;
    longint dv;
    longint t;
    logic [31:0] tw;
    dv   = (sb.divisor == '0) ? 64'sd1 : longint'({33'd0, sb.divisor});
    mode = $urandom_range(0, 9);
    if (mode <= 2) return $urandom;
    if (mode <= 6) begin
      // land near the clip limits and the rounding edges
      qv = int'($urandom_range(0, 280)) - 140;
      t  = longint'(qv) * dv + longint'($urandom_range(0, 6)) - 64'sd3;
      tw = t[31:0];
      return tw - sb.offset;
    end
    if (mode == 7) begin
      case ($urandom_range(0, 5))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        3: return 32'hffff_ffff;
        4: return 32'd0 - sb.offset;
        default: return 32'h7fff_ffff - sb.offset;
      endcase
    end
    return 32'($urandom_range(0, 511)) - 32'd256;
  endfunction

  function automatic logic [31:0] pick_divisor();
    case ($urandom_range(0, 5))
      0: return 32'd1;
      1: return 32'($urandom_range(2, 300));
      2: return 32'($urandom_range(301, 70000));
      3: return $urandom;
      4: return 32'h7fff_ffff;
      default: return 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'($urandom_range(0, 2000)) - 32'd1000;
      2: return $urandom;
      3: return 32'h8000_0000;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  task automatic send(in_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(it);
    n_items++;
    if (it.final_element) n_finals++;
    @(negedge clk_i);
  endtask

  // stop sending, let all words come back and the last item finish
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_apply(logic [31:0] div_data, logic [31:0] off_data, bit spare);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DIVISOR;
    cfg_data_i <= div_data;
    sb.write_reg(CFG_DIVISOR, div_data);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_OFFSET;
    cfg_data_i <= off_data;
    sb.write_reg(CFG_OFFSET, off_data);
    @(negedge clk_i);
    if (spare) begin
      cfg_idx_i  <= CFG_SPARE_LO;
      cfg_data_i <= $urandom;
      @(negedge clk_i);
      cfg_idx_i  <= CFG_SPARE_HI;
      cfg_data_i <= $urandom;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    n_settings++;
  endtask

  task automatic random_phase(int target);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < target) begin
      if ($urandom_range(0, 6) == 0) begin
        send(mk_item(pick_sample(), 1'($urandom_range(0, 1))));
        cnt++;
      end else begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          send(mk_item(pick_sample(), k == len - 1));
          cnt++;
        end
      end
    end
  endtask

  initial begin
    sb         = new();
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    idle_on    = 1'b1;
    n_items    = 0;
    n_finals   = 0;
    n_settings = 1;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: clip edges, full word plain and on final, partial words
    send(mk_item(32'd0, 1'b0));
    send(mk_item(32'd127, 1'b0));
    send(mk_item(32'd128, 1'b0));
    send(mk_item(-32'sd128, 1'b0));
    send(mk_item(-32'sd129, 1'b0));
    send(mk_item(32'h7fff_ffff, 1'b0));
    send(mk_item(32'h8000_0000, 1'b0));
    send(mk_item(32'hffff_ffff, 1'b1));
    send(mk_item(32'd5, 1'b1));
    send(mk_item(32'd1, 1'b0));
    send(mk_item(-32'sd1, 1'b1));
    send(mk_item(32'd100, 1'b0));
    send(mk_item(-32'sd100, 1'b0));
    send(mk_item(32'd50, 1'b1));
    drain();

    // zero divisor with bit 31 set, max offset, writes to unused indexes
    idle_on = 1'b0;
    cfg_apply(32'h8000_0000, 32'h7fff_ffff, 1'b1);
    send(mk_item(32'd1, 1'b0));
    send(mk_item(32'h8000_0000, 1'b0));
    send(mk_item(32'h8000_0081, 1'b0));
    send(mk_item(32'hffff_ff00, 1'b1));
    drain();

    idle_on = 1'b1;
    cfg_apply(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send(mk_item(32'hffff_ffff, 1'b0));
    send(mk_item(32'd0, 1'b0));
    send(mk_item(32'h7fff_ffff, 1'b0));
    send(mk_item(32'h8000_0000, 1'b1));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      cfg_apply(pick_divisor(), pick_offset(), $urandom_range(0, 3) == 0);
      random_phase(PHASE_ITEMS);
      drain();
    end

    $display("covered %0d samples, %0d vector ends, %0d register settings",
             n_items, n_finals, n_settings);
    $display("checked %0d packed words, %0d mismatches", sb.words_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
